/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

/* hdl/tsc_pkg.sv */
// ----------------------------------------------------------------------------
// tsc_pkg
// Types, codes and constants of the thermostat setpoint controller.
// ----------------------------------------------------------------------------
package tsc_pkg;

	// Event kinds carried by an item
	typedef enum logic [1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_UP     = 2'd1,
		FUNC_DOWN   = 2'd2,
		FUNC_SAMPLE = 2'd3
	} func_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SETPOINT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SETPOINT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SET_STEP        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS_BAND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EDIT_TIMEOUT    = 3'd4;

	// Configuration reset values
	localparam logic [7:0]  MIN_SETPOINT_RST    = 8'd35;
	localparam logic [7:0]  MAX_SETPOINT_RST    = 8'd75;
	localparam logic [7:0]  SET_STEP_RST        = 8'd5;
	localparam logic [7:0]  HYSTERESIS_BAND_RST = 8'd5;
	localparam logic [15:0] EDIT_TIMEOUT_RST    = 16'd5000;

	// State reset values
	localparam logic [7:0] TARGET_RST = 8'd60;

	// Sample averaging: group size and reciprocal for the divide (1..16)
	localparam int SAMPLES_PER_AVG = 10;
	localparam int SUM_W    = 12;
	localparam int CNT_W    = $clog2(SAMPLES_PER_AVG + 1);
	localparam int RECIP_SH = 16;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam logic [RECIP_W-1:0] AVG_RECIP =
		RECIP_W'(((1 << RECIP_SH) + SAMPLES_PER_AVG - 1) / SAMPLES_PER_AVG);
	localparam int PROD_W   = SUM_W + RECIP_W;

	typedef struct packed {
		logic [7:0]  min_setpoint;
		logic [7:0]  max_setpoint;
		logic [7:0]  set_step;
		logic [7:0]  hysteresis_band;
		logic [15:0] edit_timeout;
	} cfg_t;

	typedef struct packed {
		logic       relay_on;
		logic       cool_indicator;
		logic       edit_mode;
		logic [7:0] shown_value;
		logic [7:0] set_point;
		logic [7:0] average;
	} result_t;

endpackage

/* hdl/tsc_core.sv */
// ----------------------------------------------------------------------------
// tsc_core
// Controller state and its update for a single event item.
// ----------------------------------------------------------------------------
module tsc_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step_en,
	input  tsc_pkg::func_t  func,
	input  logic [7:0]      sample,
	input  tsc_pkg::cfg_t   cfg,
	output tsc_pkg::result_t res
);
	import tsc_pkg::*;

	logic              mode_q, mode_nx;
	logic [15:0]       idle_q, idle_nx;
	logic [7:0]        target_q, target_nx;
	logic [SUM_W-1:0]  sum_q, sum_nx;
	logic [CNT_W-1:0]  cnt_q, cnt_nx;
	logic [7:0]        mean_q, mean_nx;
	logic              relay_q, relay_nx;
	logic              cool_q, cool_nx;

	logic [8:0]        up_sum;
	logic [15:0]       idle_inc;
	logic [SUM_W-1:0]  sum_inc;
	logic [CNT_W-1:0]  cnt_inc;
	logic [PROD_W-1:0] avg_prod;

	assign up_sum   = {1'b0, target_q} + {1'b0, cfg.set_step};
	assign idle_inc = idle_q + 16'd1;
	assign sum_inc  = sum_q + SUM_W'(sample);
	assign cnt_inc  = cnt_q + CNT_W'(1);
	// divide by the group size: multiply by rounded-up reciprocal
	assign avg_prod = PROD_W'(sum_inc) * PROD_W'(AVG_RECIP);

	always_comb begin
		mode_nx   = mode_q;
		idle_nx   = idle_q;
		target_nx = target_q;
		sum_nx    = sum_q;
		cnt_nx    = cnt_q;
		mean_nx   = mean_q;
		case (func)
			FUNC_TICK: begin
				if (mode_q) begin
					idle_nx = idle_inc;
					if (idle_inc >= cfg.edit_timeout) begin
						mode_nx = 1'b0;
						idle_nx = '0;
					end
				end
			end
			FUNC_UP: begin
				idle_nx = '0;
				if (!mode_q) begin
					mode_nx = 1'b1;
				end else if (up_sum <= {1'b0, cfg.max_setpoint}) begin
					target_nx = up_sum[7:0];
				end
			end
			FUNC_DOWN: begin
				idle_nx = '0;
				if (!mode_q) begin
					mode_nx = 1'b1;
				end else if (target_q >= cfg.set_step &&
						(target_q - cfg.set_step) >= cfg.min_setpoint) begin
					target_nx = target_q - cfg.set_step;
				end
			end
			FUNC_SAMPLE: begin
				sum_nx = sum_inc;
				cnt_nx = cnt_inc;
				if (cnt_inc >= CNT_W'(SAMPLES_PER_AVG)) begin
					mean_nx = avg_prod[RECIP_SH +: 8];
					sum_nx  = '0;
					cnt_nx  = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Hysteresis check on the updated setpoint and average
	always_comb begin
		relay_nx = relay_q;
		cool_nx  = cool_q;
		if (({1'b0, mean_nx} + {1'b0, cfg.hysteresis_band}) < {1'b0, target_nx}) begin
			relay_nx = 1'b1;
			cool_nx  = 1'b0;
		end else if ({1'b0, mean_nx} > ({1'b0, target_nx} + {1'b0, cfg.hysteresis_band})) begin
			relay_nx = 1'b0;
			cool_nx  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			idle_q   <= '0;
			target_q <= TARGET_RST;
			sum_q    <= '0;
			cnt_q    <= '0;
			mean_q   <= '0;
			relay_q  <= 1'b0;
			cool_q   <= 1'b0;
		end else if (step_en) begin
			mode_q   <= mode_nx;
			idle_q   <= idle_nx;
			target_q <= target_nx;
			sum_q    <= sum_nx;
			cnt_q    <= cnt_nx;
			mean_q   <= mean_nx;
			relay_q  <= relay_nx;
			cool_q   <= cool_nx;
		end
	end

	assign res.relay_on       = relay_q;
	assign res.cool_indicator = cool_q;
	assign res.edit_mode      = mode_q;
	assign res.shown_value    = mode_q ? target_q : mean_q;
	assign res.set_point      = target_q;
	assign res.average        = mean_q;

endmodule

/* hdl/thermostat_setpoint_controller.sv */
// Items pass the input register, then the core's state registers (results).
// One item per cycle unless results stall; state update is one pass of logic.
// An input register holds one item while a finished result waits on stall.
// Reset (arst_n low) clears state, empties both stages, loads default config.
// ----------------------------------------------------------------------------
// thermostat_setpoint_controller
// Water heater thermostat: sample averaging, setpoint editing with timeout,
// and a hysteresis relay with a cooling indicator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module thermostat_setpoint_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	// event items
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    func,
	input  logic [7:0]                    sample,
	// result items
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          relay_on,
	output logic                          cool_indicator,
	output logic                          edit_mode,
	output logic [7:0]                    shown_value,
	output logic [7:0]                    set_point,
	output logic [7:0]                    average,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import tsc_pkg::*;

	cfg_t    cfg_q;
	logic    s1_valid_q;
	func_t   func_s1;
	logic [7:0] sample_s1;
	logic    out_valid_q;
	logic    advance;
	logic    item_take;
	logic    step_en;
	result_t res;

	// Writes are always taken; indexes past the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_setpoint    <= MIN_SETPOINT_RST;
			cfg_q.max_setpoint    <= MAX_SETPOINT_RST;
			cfg_q.set_step        <= SET_STEP_RST;
			cfg_q.hysteresis_band <= HYSTERESIS_BAND_RST;
			cfg_q.edit_timeout    <= EDIT_TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MIN_SETPOINT:    cfg_q.min_setpoint    <= cfg_data[7:0];
				CFG_MAX_SETPOINT:    cfg_q.max_setpoint    <= cfg_data[7:0];
				CFG_SET_STEP:        cfg_q.set_step        <= cfg_data[7:0];
				CFG_HYSTERESIS_BAND: cfg_q.hysteresis_band <= cfg_data[7:0];
				CFG_EDIT_TIMEOUT:    cfg_q.edit_timeout    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The state update advances whenever the result slot is free or is
	// being taken this cycle. The input register stalls only when it is
	// full and cannot advance, so one item is taken while a result waits.
	assign advance    = !out_valid_q || !result_stall;
	assign item_stall = s1_valid_q && !advance;
	assign item_take  = item_valid && !item_stall;
	assign step_en    = s1_valid_q && advance;

	// Input register: load on accept, drop once the item is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_take) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			func_s1   <= func_t'(func);
			sample_s1 <= sample;
		end
	end

	// The core's state registers are the result register: they change
	// only when a step runs, which needs the result slot free.
	tsc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(step_en),
		.func   (func_s1),
		.sample (sample_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Result valid: set by a step, cleared when taken without a new step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid   = out_valid_q;
	assign relay_on       = res.relay_on;
	assign cool_indicator = res.cool_indicator;
	assign edit_mode      = res.edit_mode;
	assign shown_value    = res.shown_value;
	assign set_point      = res.set_point;
	assign average        = res.average;

	// A held input item is never lost while the result side is stalled.
	`ASSERT_PROP(a_s1_hold, (s1_valid_q && !advance) |=> s1_valid_q, "input item dropped")
	// A waiting result is never overwritten by a step.
	`ASSERT_NEVER(a_no_overwrite, step_en && out_valid_q && result_stall, "result overwritten")
	// Without a step the visible state stays put.
	`ASSERT_PROP(a_state_still, !step_en |=> $stable(res), "state moved without an item")
	// Heating and cooling indications never overlap.
	`ASSERT_NEVER(a_relay_cool, relay_on && cool_indicator, "relay and cool both set")

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for thermostat_setpoint_controller. It sends tick, button and
// sensor events under random stalls on both sides and predicts every result
// with its own copy of the thermostat state. The run covers several register
// settings, the extremes among them, and ends with one verdict line.
// ----------------------------------------------------------------------------

// Tracks the thermostat state, queues the expected result of each accepted
// item and checks the block's results against that queue in order.
class thermostat_tracker;
	tsc_pkg::cfg_t    regs;
	logic             editing;
	logic [15:0]      idle_ticks;
	logic [7:0]       target;
	logic [11:0]      sum;
	int               count;
	logic [7:0]       mean;
	logic             heating;
	logic             cooling;
	tsc_pkg::result_t awaited[$];
	int               mismatches;
	int               events;
	int               results;
	int               reg_writes;
	int               averages;
	int               timeouts;
	int               refused_steps;
	int               relay_changes;

	function new();
		regs.min_setpoint    = tsc_pkg::MIN_SETPOINT_RST;
		regs.max_setpoint    = tsc_pkg::MAX_SETPOINT_RST;
		regs.set_step        = tsc_pkg::SET_STEP_RST;
		regs.hysteresis_band = tsc_pkg::HYSTERESIS_BAND_RST;
		regs.edit_timeout    = tsc_pkg::EDIT_TIMEOUT_RST;
		editing    = 1'b0;
		idle_ticks = '0;
		target     = tsc_pkg::TARGET_RST;
		sum        = '0;
		count      = 0;
		mean       = '0;
		heating    = 1'b0;
		cooling    = 1'b0;
	endfunction

	// Indexes past the last register are dropped.
	function void write_register(logic [tsc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
		reg_writes++;
		case (idx)
		tsc_pkg::CFG_MIN_SETPOINT:    regs.min_setpoint    = data[7:0];
		tsc_pkg::CFG_MAX_SETPOINT:    regs.max_setpoint    = data[7:0];
		tsc_pkg::CFG_SET_STEP:        regs.set_step        = data[7:0];
		tsc_pkg::CFG_HYSTERESIS_BAND: regs.hysteresis_band = data[7:0];
		tsc_pkg::CFG_EDIT_TIMEOUT:    regs.edit_timeout    = data;
		default: ;
		endcase
	endfunction

	// Apply one event to the state, run the relay check and queue the result.
	function void note_event(tsc_pkg::func_t kind, logic [7:0] value);
		logic [8:0]       raised;
		logic             was_heating;
		int               low_edge;
		int               high_edge;
		tsc_pkg::result_t exp;
		events++;
		was_heating = heating;
		case (kind)
		tsc_pkg::FUNC_TICK: begin
			if (editing) begin
				idle_ticks = idle_ticks + 16'd1;
				if (idle_ticks >= regs.edit_timeout) begin
					editing    = 1'b0;
					idle_ticks = '0;
					timeouts++;
				end
			end
		end
		tsc_pkg::FUNC_UP, tsc_pkg::FUNC_DOWN: begin
			if (!editing) begin
				editing = 1'b1;
			end else if (kind == tsc_pkg::FUNC_UP) begin
				raised = {1'b0, target} + regs.set_step;
				if (raised <= regs.max_setpoint)
					target = raised[7:0];
				else
					refused_steps++;
			end else if (target >= regs.set_step &&
					target - regs.set_step >= regs.min_setpoint) begin
				target = target - regs.set_step;
			end else begin
				refused_steps++;
			end
			idle_ticks = '0;
		end
		default: begin
			sum = sum + value;
			count++;
			if (count >= tsc_pkg::SAMPLES_PER_AVG) begin
				mean  = 8'(sum / tsc_pkg::SAMPLES_PER_AVG);
				sum   = '0;
				count = 0;
				averages++;
			end
		end
		endcase
		low_edge  = int'(target) - int'(regs.hysteresis_band);
		high_edge = int'(target) + int'(regs.hysteresis_band);
		if (int'(mean) < low_edge) begin
			heating = 1'b1;
			cooling = 1'b0;
		end else if (int'(mean) > high_edge) begin
			heating = 1'b0;
			cooling = 1'b1;
		end
		if (heating != was_heating)
			relay_changes++;
		exp.relay_on       = heating;
		exp.cool_indicator = cooling;
		exp.edit_mode      = editing;
		exp.shown_value    = editing ? target : mean;
		exp.set_point      = target;
		exp.average        = mean;
		awaited.push_back(exp);
	endfunction

	task flag_mismatch(string msg);
		mismatches++;
		$display("[%0t] result %0d: %s", $time, results, msg);
	endtask

	task compare_field(string name, logic [7:0] got_v, logic [7:0] exp_v);
		if (got_v !== exp_v)
			flag_mismatch($sformatf("%s is %0d, expected %0d", name, got_v, exp_v));
	endtask

	task check_result(tsc_pkg::result_t got);
		tsc_pkg::result_t exp;
		results++;
		if (awaited.size() == 0) begin
			flag_mismatch($sformatf("result %h arrived with nothing expected", got));
			return;
		end
		exp = awaited.pop_front();
		compare_field("relay_on", got.relay_on, exp.relay_on);
		compare_field("cool_indicator", got.cool_indicator, exp.cool_indicator);
		compare_field("edit_mode", got.edit_mode, exp.edit_mode);
		compare_field("shown_value", got.shown_value, exp.shown_value);
		compare_field("set_point", got.set_point, exp.set_point);
		compare_field("average", got.average, exp.average);
	endtask
endclass

module tb;
	import tsc_pkg::*;

	// Length of the forced receiver hold-off that fills the block up
	localparam int CHOKE_CYCLES   = 60;
	// Quiet cycles (no handshake on any channel) before the run is abandoned
	localparam int WATCHDOG_LIMIT = 1000;
	// Cycles to keep watching after the last expected result
	localparam int TAIL_CYCLES    = 10;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	logic [1:0]           func;
	logic [7:0]           sample;
	logic                 result_valid;
	logic                 result_stall;
	logic                 relay_on;
	logic                 cool_indicator;
	logic                 edit_mode;
	logic [7:0]           shown_value;
	logic [7:0]           set_point;
	logic [7:0]           average;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	// Idle odds in percent for each side, set per phase by the main sequence
	int                send_idle_pct;
	int                recv_idle_pct;
	// Hold-off requests from the main sequence and how many the receiver served
	int                choke_asked;
	int                choke_served;
	int                settings_applied;
	// Temperature the sensor readings currently hover around
	logic [7:0]        temp_level;
	thermostat_tracker tracker;

	thermostat_setpoint_controller dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Monitor: check results before noting the item of the same edge, since
	// an item never shows up on the result ports in the cycle it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				tracker.check_result(result_t'({relay_on, cool_indicator, edit_mode,
					shown_value, set_point, average}));
			if (item_valid && !item_stall)
				tracker.note_event(func_t'(func), sample);
			if (cfg_valid && cfg_ready)
				tracker.write_register(cfg_index, cfg_data);
		end
	end

	// Receiver: stall at random, or hold off for a long stretch on request so
	// the block backs up and stalls its input.
	initial begin : receiver
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (choke_served != choke_asked) begin
				result_stall <= 1'b1;
				repeat (CHOKE_CYCLES - 1) @(posedge clk);
				choke_served++;
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Watchdog: give up after a long stretch with no handshake anywhere.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog: %0d quiet cycles, %0d results still outstanding",
			WATCHDOG_LIMIT, tracker.awaited.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [7:0] clamp_degrees(int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return 8'(v);
	endfunction

	// Pick a sensor reading. At the start of each averaging group move the
	// level to somewhere around the setpoint so the relay sees both edges and
	// the hold zone; now and then send a reading from the full range.
	function automatic logic [7:0] next_reading();
		int spread;
		if (tracker.count == 0) begin
			spread = int'(tracker.regs.hysteresis_band) + 12;
			temp_level = clamp_degrees(int'(tracker.target) +
				int'($urandom_range(2 * spread)) - spread);
		end
		if ($urandom_range(99) < 15)
			return 8'($urandom);
		return clamp_degrees(int'(temp_level) + int'($urandom_range(8)) - 4);
	endfunction

	function automatic cfg_t make_setting(logic [7:0] lo, logic [7:0] hi,
			logic [7:0] stride, logic [7:0] band, logic [15:0] patience);
		cfg_t s;
		s.min_setpoint    = lo;
		s.max_setpoint    = hi;
		s.set_step        = stride;
		s.hysteresis_band = band;
		s.edit_timeout    = patience;
		return s;
	endfunction

	// Mostly ordered limits, now and then crossed; short timeouts so edit
	// mode comes and goes.
	function automatic cfg_t random_setting();
		logic [7:0] lo;
		logic [7:0] hi;
		lo = 8'($urandom_range(120));
		hi = 8'($urandom_range(255, lo));
		if ($urandom_range(3) == 0)
			return make_setting(hi, lo, 8'($urandom_range(25, 1)),
				8'($urandom_range(30)), 16'($urandom_range(40, 1)));
		return make_setting(lo, hi, 8'($urandom_range(25, 1)),
			8'($urandom_range(30)), 16'($urandom_range(40, 1)));
	endfunction

	// Offer one item, with random idle cycles ahead of it, and hold it until
	// the block takes it.
	task automatic send_event(func_t kind, logic [7:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		func       <= kind;
		sample     <= value;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Stop offering items and wait until every expected result is in.
	task automatic drain();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.awaited.size() != 0);
	endtask

	// Drain, then load every register. Junk in the upper data bits of the
	// 8-bit registers must be dropped; optionally hit the unused indexes too.
	task automatic apply_setting(cfg_t s, bit stray_writes);
		drain();
		write_register(CFG_MIN_SETPOINT, {8'($urandom), s.min_setpoint});
		write_register(CFG_MAX_SETPOINT, {8'($urandom), s.max_setpoint});
		write_register(CFG_SET_STEP, {8'($urandom), s.set_step});
		write_register(CFG_HYSTERESIS_BAND, {8'($urandom), s.hysteresis_band});
		write_register(CFG_EDIT_TIMEOUT, s.edit_timeout);
		if (stray_writes)
			for (int i = int'(CFG_EDIT_TIMEOUT) + 1; i < (1 << CFG_IDX_W); i++)
				write_register(CFG_IDX_W'(i), 16'($urandom));
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	task automatic feed_random(int n);
		int roll;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < 45)
				send_event(FUNC_SAMPLE, next_reading());
			else if (roll < 70)
				send_event(FUNC_TICK, 8'($urandom));
			else if (roll < 85)
				send_event(FUNC_UP, 8'($urandom));
			else
				send_event(FUNC_DOWN, 8'($urandom));
		end
	endtask

	initial begin : main
		tracker          = new();
		send_idle_pct    = 22;
		recv_idle_pct    = 74;
		choke_asked      = 0;
		choke_served     = 0;
		settings_applied = 0;
		temp_level       = TARGET_RST;
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		func       <= FUNC_TICK;
		sample     <= 8'd0;
		cfg_valid  <= 1'b0;
		cfg_index  <= CFG_MIN_SETPOINT;
		cfg_data   <= 16'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idles often, receiver more often.
		// Default registers: ticks outside edit mode, a hot group of readings
		// with both extremes, then walk the setpoint into the upper limit.
		apply_setting(make_setting(MIN_SETPOINT_RST, MAX_SETPOINT_RST, SET_STEP_RST,
			HYSTERESIS_BAND_RST, EDIT_TIMEOUT_RST), 1'b0);
		send_event(FUNC_TICK, 8'hFF);
		send_event(FUNC_TICK, 8'h00);
		send_event(FUNC_DOWN, 8'hA5);
		send_event(FUNC_SAMPLE, 8'd0);
		repeat (SAMPLES_PER_AVG - 1)
			send_event(FUNC_SAMPLE, 8'd255);
		repeat (4)
			send_event(FUNC_UP, 8'h5A);
		repeat (2)
			send_event(FUNC_DOWN, 8'h00);
		send_event(FUNC_TICK, 8'h3C);
		feed_random(130);

		// Widest limits, largest step, no band, timeout of one; also write
		// the indexes past the register list.
		apply_setting(make_setting(8'd0, 8'd255, 8'd255, 8'd0, 16'd1), 1'b1);
		feed_random(130);

		// Crossed limits, step of one, widest band, longest timeout.
		apply_setting(make_setting(8'd255, 8'd0, 8'd1, 8'd255, 16'hFFFF), 1'b0);
		feed_random(130);

		// Swap the idle odds.
		send_idle_pct = 74;
		recv_idle_pct = 22;

		// Zero step and zero timeout: presses move nothing but still restart
		// the timeout, and the first tick in edit mode leaves it.
		apply_setting(make_setting(8'd20, 8'd200, 8'd0, 8'd3, 16'd0), 1'b0);
		send_event(FUNC_UP, 8'h01);
		send_event(FUNC_UP, 8'h80);
		send_event(FUNC_DOWN, 8'h7F);
		send_event(FUNC_TICK, 8'h00);
		send_event(FUNC_TICK, 8'hFF);
		send_event(FUNC_DOWN, 8'h00);
		send_event(FUNC_TICK, 8'h55);
		feed_random(120);

		apply_setting(random_setting(), 1'b0);
		feed_random(140);
		apply_setting(random_setting(), 1'b0);
		feed_random(140);

		// No idling at all; first choke the output for a long stretch while
		// items keep coming so the block fills and stalls its input.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_setting(make_setting(8'd40, 8'd90, 8'd3, 8'd2, 16'd20), 1'b0);
		choke_asked++;
		feed_random(140);
		apply_setting(random_setting(), 1'b0);
		feed_random(140);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d events under %0d register settings, %0d results checked, %0d writes",
			tracker.events, settings_applied, tracker.results, tracker.reg_writes);
		$display("Saw %0d averages, %0d edit timeouts, %0d refused steps, %0d relay changes",
			tracker.averages, tracker.timeouts, tracker.refused_steps, tracker.relay_changes);
		if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
